// ----- hdl/cfdp_pkg.sv -----
package cfdp_pkg;

	localparam int ID_MAX_OCTETS = 8;
	localparam logic [63:0] ID_MASK = (ID_MAX_OCTETS >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * ID_MAX_OCTETS)) - 64'd1);

	typedef enum logic [3:0] {
		PH_OCT0     = 4'd0,
		PH_LEN_HI   = 4'd1,
		PH_LEN_LO   = 4'd2,
		PH_OCT3     = 4'd3,
		PH_SRC      = 4'd4,
		PH_SEQ      = 4'd5,
		PH_DST      = 4'd6,
		PH_META_LEN = 4'd7,
		PH_META     = 4'd8,
		PH_OFFSET   = 4'd9,
		PH_FILE     = 4'd10,
		PH_DIR      = 4'd11,
		PH_TAIL     = 4'd12,
		PH_SKIP     = 4'd13
	} phase_t;

	typedef enum logic [2:0] {
		KIND_HEADER    = 3'd0,
		KIND_METADATA  = 3'd1,
		KIND_OFFSET    = 3'd2,
		KIND_FILE_BYTE = 3'd3,
		KIND_DIRECTIVE = 3'd4,
		KIND_DONE      = 3'd5,
		KIND_ERROR     = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_VERSION   = 2'd1,
		ERR_TRUNCATED = 2'd2,
		ERR_SHORT     = 2'd3
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} octet_t;

	typedef struct packed {
		kind_t       kind;
		err_t        error_code;
		logic [6:0]  header_flags;
		logic [15:0] data_field_len;
		logic [63:0] src_entity_id;
		logic [63:0] sequence_number;
		logic [63:0] dest_entity_id;
		logic [1:0]  continuation_state;
		logic [63:0] file_offset;
		logic [7:0]  payload_byte;
		logic        last;
	} result_t;

	typedef struct packed {
		logic    emit;
		result_t item;
	} step_t;

endpackage

// ----- hdl/cfdp_parse_core.sv -----
module cfdp_parse_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  cfdp_pkg::octet_t octet,
	output cfdp_pkg::step_t  res
);
	import cfdp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [6:0]  flags_q, flags_d;
	logic [15:0] flen_q, flen_d;
	logic [3:0]  id_oct_q, id_oct_d;
	logic [3:0]  seq_oct_q, seq_oct_d;
	logic [63:0] src_q, src_d;
	logic [63:0] seq_q, seq_d;
	logic [63:0] dst_q, dst_d;
	logic [63:0] off_q, off_d;
	logic [5:0]  meta_left_q, meta_left_d;
	logic [1:0]  cont_q, cont_d;
	logic [15:0] left_q, left_d;

	logic [7:0]  b;
	logic        eof;
	logic [1:0]  crc_len;
	logic [3:0]  off_len;
	logic        in_field;
	logic [15:0] left_dec;
	logic        fin;
	logic [3:0]  cnt_inc;
	logic [5:0]  meta_dec;
	logic [16:0] payload_len;
	logic [4:0]  need_len;
	logic [16:0] room_len;
	logic [16:0] meta_need;
	logic        have;
	logic        quiet;
	kind_t       kind;
	err_t        err;
	logic [7:0]  pay;

	assign b        = octet.data_byte;
	assign eof      = octet.end_of_frame;
	assign crc_len  = flags_q[3] ? 2'd2 : 2'd0;
	assign off_len  = flags_q[2] ? 4'd8 : 4'd4;
	assign in_field = (phase_q >= PH_META_LEN) && (phase_q <= PH_TAIL);
	assign left_dec = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;
	assign fin      = in_field && (left_dec == 16'd0);
	assign cnt_inc  = cnt_q + 4'd1;
	assign meta_dec = (meta_left_q != 6'd0) ? meta_left_q - 6'd1 : 6'd0;
	assign payload_len = {1'b0, flen_q} - 17'(crc_len);
	assign need_len = flags_q[6] ? (5'(flags_q[0]) + 5'(off_len)) : 5'd1;
	assign room_len = {1'b0, left_q} - 17'(crc_len);
	assign meta_need = 17'd1 + 17'(b[5:0]) + 17'(off_len);

	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		flags_d     = flags_q;
		flen_d      = flen_q;
		id_oct_d    = id_oct_q;
		seq_oct_d   = seq_oct_q;
		src_d       = src_q;
		seq_d       = seq_q;
		dst_d       = dst_q;
		off_d       = off_q;
		meta_left_d = meta_left_q;
		cont_d      = cont_q;
		left_d      = in_field ? left_dec : left_q;
		have        = 1'b0;
		quiet       = 1'b0;
		kind        = KIND_HEADER;
		err         = ERR_NONE;
		pay         = 8'd0;

		unique case (phase_q)
			PH_OCT0: begin
				if (b[7:5] != 3'd1) begin
					err = ERR_VERSION;
				end else begin
					flags_d     = {b[4:0], 2'b00};
					flen_d      = 16'd0;
					src_d       = 64'd0;
					seq_d       = 64'd0;
					dst_d       = 64'd0;
					off_d       = 64'd0;
					cont_d      = 2'd0;
					meta_left_d = 6'd0;
					cnt_d       = 4'd0;
					left_d      = 16'd0;
					phase_d     = PH_LEN_HI;
				end
			end
			PH_LEN_HI: begin
				flen_d  = {b, 8'h00};
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				flen_d  = {flen_q[15:8], b};
				phase_d = PH_OCT3;
			end
			PH_OCT3: begin
				id_oct_d  = {1'b0, b[6:4]} + 4'd1;
				seq_oct_d = {1'b0, b[2:0]} + 4'd1;
				if (flags_q[6]) begin
					flags_d = flags_q | {5'd0, b[7], b[3]};
				end
				cnt_d   = 4'd0;
				phase_d = PH_SRC;
			end
			PH_SRC: begin
				src_d = {src_q[55:0], b} & ID_MASK;
				if (cnt_inc >= id_oct_q) begin
					cnt_d   = 4'd0;
					phase_d = PH_SEQ;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_SEQ: begin
				seq_d = {seq_q[55:0], b} & ID_MASK;
				if (cnt_inc >= seq_oct_q) begin
					cnt_d   = 4'd0;
					phase_d = PH_DST;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_DST: begin
				dst_d = {dst_q[55:0], b} & ID_MASK;
				if (cnt_inc < id_oct_q) begin
					cnt_d = cnt_inc;
				end else begin
					cnt_d = 4'd0;
					if ((crc_len != 2'd0) && (flen_q < 16'd2)) begin
						err = ERR_SHORT;
					end else if (payload_len < 17'(need_len)) begin
						err = ERR_TRUNCATED;
					end else begin
						left_d = flen_q;
						have   = 1'b1;
						kind   = KIND_HEADER;
						if (!flags_q[6]) begin
							phase_d = PH_DIR;
						end else if (flags_q[0]) begin
							phase_d = PH_META_LEN;
						end else begin
							phase_d = PH_OFFSET;
						end
					end
				end
			end
			PH_META_LEN: begin
				cont_d      = b[7:6];
				meta_left_d = b[5:0];
				if ((left_q < 16'(crc_len)) || (room_len < meta_need)) begin
					err = ERR_TRUNCATED;
				end else begin
					phase_d = (b[5:0] != 6'd0) ? PH_META : PH_OFFSET;
				end
			end
			PH_META: begin
				have        = 1'b1;
				kind        = KIND_METADATA;
				pay         = b;
				meta_left_d = meta_dec;
				if (meta_dec == 6'd0) begin
					phase_d = PH_OFFSET;
				end
			end
			PH_OFFSET: begin
				off_d = {off_q[55:0], b};
				if (cnt_inc >= off_len) begin
					cnt_d   = 4'd0;
					have    = 1'b1;
					kind    = KIND_OFFSET;
					phase_d = PH_FILE;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			PH_FILE: begin
				if (left_q > 16'(crc_len)) begin
					have = 1'b1;
					kind = KIND_FILE_BYTE;
					pay  = b;
				end
			end
			PH_DIR: begin
				have    = 1'b1;
				kind    = KIND_DIRECTIVE;
				pay     = b;
				phase_d = PH_TAIL;
			end
			PH_TAIL: begin
			end
			PH_SKIP: begin
				quiet = 1'b1;
				if (eof) begin
					phase_d = PH_OCT0;
				end
			end
			default: begin
				quiet   = 1'b1;
				phase_d = eof ? PH_OCT0 : PH_SKIP;
			end
		endcase

		res.emit                     = 1'b0;
		res.item.kind                = kind;
		res.item.error_code          = ERR_NONE;
		res.item.header_flags        = flags_d;
		res.item.data_field_len      = flen_d;
		res.item.src_entity_id       = src_d;
		res.item.sequence_number     = seq_d;
		res.item.dest_entity_id      = dst_d;
		res.item.continuation_state  = cont_d;
		res.item.file_offset         = off_d;
		res.item.payload_byte        = pay;
		res.item.last                = 1'b0;

		if (!quiet) begin
			priority if (err != ERR_NONE || (!fin && eof)) begin
				res.emit = 1'b1;
				res.item = '0;
				res.item.kind       = KIND_ERROR;
				res.item.error_code = (err != ERR_NONE) ? err : ERR_TRUNCATED;
				res.item.last       = 1'b1;
				phase_d = (eof || err == ERR_NONE) ? PH_OCT0 : PH_SKIP;
			end else if (fin) begin
				res.emit      = 1'b1;
				res.item.last = 1'b1;
				if (!have) begin
					res.item.kind         = KIND_DONE;
					res.item.payload_byte = 8'd0;
				end
				phase_d = eof ? PH_OCT0 : PH_SKIP;
			end else if (have) begin
				res.emit = 1'b1;
			end else begin
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OCT0;
			cnt_q       <= 4'd0;
			flags_q     <= 7'd0;
			flen_q      <= 16'd0;
			id_oct_q    <= 4'd1;
			seq_oct_q   <= 4'd1;
			src_q       <= 64'd0;
			seq_q       <= 64'd0;
			dst_q       <= 64'd0;
			off_q       <= 64'd0;
			meta_left_q <= 6'd0;
			cont_q      <= 2'd0;
			left_q      <= 16'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			flags_q     <= flags_d;
			flen_q      <= flen_d;
			id_oct_q    <= id_oct_d;
			seq_oct_q   <= seq_oct_d;
			src_q       <= src_d;
			seq_q       <= seq_d;
			dst_q       <= dst_d;
			off_q       <= off_d;
			meta_left_q <= meta_left_d;
			cont_q      <= cont_d;
			left_q      <= left_d;
		end
	end

endmodule

// ----- hdl/cfdp_pdu_stream_parser.sv -----
// CFDP PDU stream parser.
// The octet channel takes one PDU octet per transfer, with end_of_frame marking
// the last octet the link delivers. The result channel returns at most one item
// per octet: the decoded header, metadata bytes, the file offset, file bytes,
// the directive code, a done marker, or an error with last set.
// Each octet is decoded in the cycle it is accepted, and its result appears in
// the output register on the next cycle; while the receiver does not stall,
// throughput is one octet per cycle. A single decode step lies between the
// parser state registers and the output register.
// The octet channel stays ready while the output register is empty or its
// item is being taken in the same cycle. When the receiver stalls with a
// result pending, octet_ready drops and the held result stays unchanged until
// it is transferred. Octets that produce no result still need the output
// register to be free.
// Reset clears the parser to wait for octet zero of a new PDU and empties the
// output register.
module cfdp_pdu_stream_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              octet_valid,
	output logic              octet_ready,
	input  cfdp_pkg::octet_t  octet,
	output logic              result_valid,
	input  logic              result_ready,
	output cfdp_pkg::result_t result
);
	import cfdp_pkg::*;

	logic    step;
	step_t   res;
	logic    valid_q;
	result_t result_q;

	assign octet_ready  = !valid_q || result_ready;
	assign step         = octet_valid && octet_ready;
	assign result_valid = valid_q;
	assign result       = result_q;

	cfdp_parse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.octet  (octet),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step && res.emit) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			result_q <= res.item;
		end
	end

endmodule

// ----- hdl/cfdp_checker.sv -----
module cfdp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              octet_ready,
	input logic              result_valid,
	input logic              result_ready,
	input cfdp_pkg::result_t result
);
	import cfdp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("Stalled result changed or dropped.");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> octet_ready)
		else $error("Octet channel stalled with an empty output register.");

	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_ERROR |->
			result.last && result.error_code != ERR_NONE &&
			result.header_flags == 7'd0 && result.payload_byte == 8'd0 &&
			result.file_offset == 64'd0)
		else $error("Error result is malformed.");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_ERROR |->
			result.error_code == ERR_NONE &&
			(result.kind != KIND_DONE || (result.last && result.payload_byte == 8'd0)))
		else $error("Non-error result carries an error code or a bad done marker.");

endmodule

bind cfdp_pdu_stream_parser cfdp_checker u_cfdp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.octet_ready  (octet_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
